### rtl/line_area_linear_resampler_top_macros.svh
// Assertion macros used by the resampler top level.
`ifndef LINE_AREA_LINEAR_RESAMPLER_TOP_MACROS_SVH
`define LINE_AREA_LINEAR_RESAMPLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LALR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lalr assertion failed");
`define LALR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lalr assertion failed");
`else
`define LALR_ASSERT_IMPL(lbl, ante, cons)
`define LALR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/lalr_pkg.sv
// Types and constants of the line resampler.
`default_nettype none
package lalr_pkg;
	localparam int MAX_LINE_LEN = 4096;
	localparam int MAX_UPSCALE  = 32;
	localparam int LEN_W   = 13;
	localparam int POS_W   = 12;
	localparam int X_W     = 40;
	localparam int RUN_W   = 52;
	localparam int MUL_W   = 14;
	localparam int VAL_W   = 53;
	localparam int LO_W    = 27;
	localparam int ACC_W   = 56;
	localparam int VALUE_W = 44;
	localparam int DIV_W   = 27;
	localparam int PR_W    = 15;

	localparam logic [2:0] REG_SRC_LEN = 3'd0;
	localparam logic [2:0] REG_DST_LEN = 3'd1;
	localparam logic [2:0] REG_PREMUL  = 3'd2;
	localparam logic [2:0] REG_NORM    = 3'd3;
	localparam logic [2:0] REG_SCALE   = 3'd4;

	typedef struct packed {
		logic [31:0] sample;
		logic [7:0]  alpha;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   position;
		logic               line_end;
	} out_item_t;

	typedef struct packed {
		logic [MUL_W-1:0] mul;
		logic [VAL_W-1:0] val;
	} term_t;

	// One result to compute: the sum of three products.
	typedef struct packed {
		term_t [2:0]      terms;
		logic [POS_W-1:0] position;
		logic             line_end;
	} job_t;

	typedef struct packed {
		logic [LEN_W-1:0] src_len;
		logic [LEN_W-1:0] dst_len;
		logic             premul;
		logic             norm;
		logic [DIV_W-1:0] scale;
	} cfg_t;
endpackage
`default_nettype wire

### rtl/lalr_queue.sv
// Four-entry job queue between the front and the back.
`default_nettype none
module lalr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	output logic           wr_full,
	input  lalr_pkg::job_t wr_job,
	input  logic           rd,
	output logic           rd_empty,
	output lalr_pkg::job_t rd_job
);
	import lalr_pkg::*;

	job_t       mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;

	assign wr_full  = (cnt_q == 3'd4);
	assign rd_empty = (cnt_q == 3'd0);
	assign rd_job   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !wr_full) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (wr && !wr_full) begin
				wp_q <= wp_q + 2'd1;
			end
			if (rd && !rd_empty) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'((wr && !wr_full) ? 1 : 0) - 3'((rd && !rd_empty) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

### rtl/lalr_front.sv
// Front end: accepts samples, tracks the line position and issues result jobs.
`default_nettype none
module lalr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  lalr_pkg::cfg_t     cfg,
	input  logic               restart,
	input  logic               push,
	output logic               full,
	input  lalr_pkg::in_item_t in_item,
	output logic               job_push,
	output lalr_pkg::job_t     job,
	input  logic               job_full
);
	import lalr_pkg::*;

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_SETUP = 3'd1;
	localparam logic [2:0] F_START = 3'd2;
	localparam logic [2:0] F_LOOP  = 3'd3;
	localparam logic [2:0] F_EDGE  = 3'd4;

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_BODY  = 2'd1;
	localparam logic [1:0] PH_FINAL = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	logic [2:0]       fst_q, fst_d;
	logic [1:0]       ph_q, ph_d;
	logic [PR_W-1:0]  pr_q, pr_d;
	logic [LEN_W-1:0] cm_q, cm_d;
	logic [X_W-1:0]   cv_q, cv_d;
	logic [RUN_W-1:0] run_q, run_d;
	logic [X_W-1:0]   prev_q, prev_d;
	logic [X_W-1:0]   cur_q, cur_d;
	logic [LEN_W-1:0] erc_q, erc_d;
	logic [LEN_W-1:0] ek_q, ek_d;
	logic [LEN_W-1:0] oi_q, oi_d;
	logic [LEN_W-1:0] ii_q, ii_d;
	logic [X_W-1:0]   x_q, x_d;

	logic [LEN_W-1:0] s, d, d_m1, oi_inc, stop;
	logic [MUL_W-1:0] w1, w2;
	logic             down, finish;
	logic [PR_W-1:0]  pr_e, pr1;
	logic [LEN_W-1:0] cm_e;
	logic [X_W-1:0]   cv_e;
	logic [RUN_W-1:0] run_e, run1;
	logic [1:0]       ph_e;

	assign s      = cfg.src_len;
	assign d      = cfg.dst_len;
	assign d_m1   = d - LEN_W'(1);
	assign oi_inc = oi_q + LEN_W'(1);
	assign w1     = {s, 1'b0};
	assign w2     = {d, 1'b0};
	assign down   = (d < s);
	assign stop   = (d > erc_q) ? d - erc_q : '0;
	assign full   = (fst_q != F_IDLE);

	// A new line starts its downscale state on the first sample.
	always_comb begin
		if (ph_q == PH_START) begin
			pr_e  = PR_W'(s);
			cm_e  = '0;
			cv_e  = '0;
			run_e = '0;
			ph_e  = (d == LEN_W'(1)) ? PH_FINAL : PH_BODY;
		end else begin
			pr_e  = pr_q;
			cm_e  = cm_q;
			cv_e  = cv_q;
			run_e = run_q;
			ph_e  = ph_q;
		end
		if (pr_e >= PR_W'(d)) begin
			pr1  = pr_e - PR_W'(d);
			run1 = run_e + RUN_W'(x_q);
		end else begin
			pr1  = pr_e;
			run1 = run_e;
		end
	end

	always_comb begin
		fst_d    = fst_q;
		ph_d     = ph_q;
		pr_d     = pr_q;
		cm_d     = cm_q;
		cv_d     = cv_q;
		run_d    = run_q;
		prev_d   = prev_q;
		cur_d    = cur_q;
		erc_d    = erc_q;
		ek_d     = ek_q;
		oi_d     = oi_q;
		ii_d     = ii_q;
		x_d      = x_q;
		finish   = 1'b0;
		job_push = 1'b0;
		job          = '0;
		job.position = oi_q[POS_W-1:0];
		job.line_end = (oi_q == d_m1);
		unique case (fst_q)
			F_IDLE: begin
				if (push) begin
					x_d   = cfg.premul ? in_item.sample * in_item.alpha : X_W'(in_item.sample);
					fst_d = F_SETUP;
				end
			end
			F_SETUP: begin
				if (down) begin
					unique case (ph_e)
						PH_BODY: begin
							if (pr_e >= PR_W'(d)) begin
								ph_d   = ph_e;
								pr_d   = pr1;
								run_d  = run1;
								cm_d   = cm_e;
								cv_d   = cv_e;
								finish = 1'b1;
							end else if (!job_full) begin
								job_push           = 1'b1;
								job.terms[0].mul   = MUL_W'(cm_e);
								job.terms[0].val   = VAL_W'(cv_e);
								job.terms[1].mul   = MUL_W'(d);
								job.terms[1].val   = VAL_W'(run_e);
								job.terms[2].mul   = pr_e[MUL_W-1:0];
								job.terms[2].val   = VAL_W'(x_q);
								cm_d   = d - pr_e[LEN_W-1:0];
								cv_d   = x_q;
								pr_d   = pr_e + PR_W'(s) - PR_W'(d);
								run_d  = '0;
								oi_d   = oi_inc;
								ph_d   = (oi_inc >= d_m1) ? PH_FINAL : PH_BODY;
								finish = 1'b1;
							end
						end
						PH_FINAL: begin
							if (pr1 >= PR_W'(d)) begin
								ph_d   = ph_e;
								pr_d   = pr1;
								run_d  = run1;
								cm_d   = cm_e;
								cv_d   = cv_e;
								finish = 1'b1;
							end else if (!job_full) begin
								job_push         = 1'b1;
								job.terms[0].mul = MUL_W'(d);
								job.terms[0].val = VAL_W'(run1);
								job.terms[1].mul = MUL_W'(cm_e);
								job.terms[1].val = VAL_W'(cv_e);
								ph_d   = PH_DONE;
								pr_d   = pr1;
								run_d  = run1;
								oi_d   = oi_inc;
								finish = 1'b1;
							end
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end else begin
					unique case (ph_q)
						PH_START: begin
							erc_d = '0;
							pr_d  = PR_W'(s);
							fst_d = F_START;
						end
						PH_BODY: begin
							if (ii_q == LEN_W'(1)) begin
								cur_d = x_q;
							end else begin
								pr_d   = (pr_q >= PR_W'(w2)) ? pr_q - PR_W'(w2) : '0;
								prev_d = cur_q;
								cur_d  = x_q;
							end
							fst_d = F_LOOP;
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			F_START: begin
				// pr holds the running edge position until the body begins.
				if (pr_q <= PR_W'(d)) begin
					if (!job_full) begin
						job_push         = 1'b1;
						job.terms[0].mul = w2;
						job.terms[0].val = VAL_W'(x_q);
						pr_d  = pr_q + PR_W'(w1);
						erc_d = erc_q + LEN_W'(1);
						oi_d  = oi_inc;
					end
				end else begin
					pr_d   = pr_q - PR_W'(d);
					prev_d = x_q;
					ph_d   = PH_BODY;
					finish = 1'b1;
				end
			end
			F_LOOP: begin
				if (oi_q < stop && pr_q < PR_W'(w2)) begin
					if (!job_full) begin
						job_push         = 1'b1;
						job.terms[0].mul = pr_q[MUL_W-1:0];
						job.terms[0].val = VAL_W'(cur_q);
						job.terms[1].mul = w2 - pr_q[MUL_W-1:0];
						job.terms[1].val = VAL_W'(prev_q);
						pr_d = pr_q + PR_W'(w1);
						oi_d = oi_inc;
					end
				end else if (oi_q >= stop) begin
					ek_d  = '0;
					fst_d = F_EDGE;
				end else begin
					finish = 1'b1;
				end
			end
			F_EDGE: begin
				if (ek_q < erc_q) begin
					if (!job_full) begin
						job_push         = 1'b1;
						job.terms[0].mul = w2;
						job.terms[0].val = VAL_W'(cur_q);
						ek_d = ek_q + LEN_W'(1);
						oi_d = oi_inc;
					end
				end else begin
					ph_d   = PH_DONE;
					finish = 1'b1;
				end
			end
			default: begin
				fst_d = F_IDLE;
			end
		endcase
		if (finish) begin
			fst_d = F_IDLE;
			ii_d  = ii_q + LEN_W'(1);
			if (ii_d >= s) begin
				ph_d   = PH_START;
				ii_d   = '0;
				oi_d   = '0;
				pr_d   = '0;
				cm_d   = '0;
				cv_d   = '0;
				run_d  = '0;
				prev_d = '0;
				cur_d  = '0;
				erc_d  = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_q  <= x_d;
		ek_q <= ek_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q  <= F_IDLE;
			ph_q   <= PH_START;
			pr_q   <= '0;
			cm_q   <= '0;
			cv_q   <= '0;
			run_q  <= '0;
			prev_q <= '0;
			cur_q  <= '0;
			erc_q  <= '0;
			oi_q   <= '0;
			ii_q   <= '0;
		end else if (restart) begin
			fst_q  <= F_IDLE;
			ph_q   <= PH_START;
			pr_q   <= '0;
			cm_q   <= '0;
			cv_q   <= '0;
			run_q  <= '0;
			prev_q <= '0;
			cur_q  <= '0;
			erc_q  <= '0;
			oi_q   <= '0;
			ii_q   <= '0;
		end else begin
			fst_q  <= fst_d;
			ph_q   <= ph_d;
			pr_q   <= pr_d;
			cm_q   <= cm_d;
			cv_q   <= cv_d;
			run_q  <= run_d;
			prev_q <= prev_d;
			cur_q  <= cur_d;
			erc_q  <= erc_d;
			oi_q   <= oi_d;
			ii_q   <= ii_d;
		end
	end
endmodule
`default_nettype wire

### rtl/lalr_back.sv
// Back end: multiply-accumulates each job, then normalizes or saturates it.
`default_nettype none
module lalr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lalr_pkg::cfg_t      cfg,
	input  logic                job_empty,
	input  lalr_pkg::job_t      job,
	output logic                job_pop,
	output logic                empty,
	input  logic                pop,
	output lalr_pkg::out_item_t out_item
);
	import lalr_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_MUL  = 2'd1;
	localparam logic [1:0] B_DIV  = 2'd2;
	localparam logic [1:0] B_OUT  = 2'd3;
	localparam logic [5:0] MUL_LAST = 6'd5;
	localparam logic [5:0] DIV_LAST = 6'(ACC_W - 1);
	localparam logic [ACC_W-1:0] VALUE_MAX = ACC_W'({VALUE_W{1'b1}});

	logic [1:0]        bst_q;
	job_t              job_q;
	logic [5:0]        cnt_q;
	logic [ACC_W-1:0]  acc_q, acc_next;
	logic [DIV_W-1:0]  rem_q;
	logic [7:0]        quo_q;
	out_item_t         res_q;
	logic              rv_q;

	term_t             term;
	logic [LO_W-1:0]   part;
	logic [MUL_W+LO_W-1:0] pp;
	logic [DIV_W:0]    trial;
	logic              out_free;

	assign term     = job_q.terms[cnt_q[2:1]];
	assign part     = cnt_q[0] ? LO_W'(term.val[VAL_W-1:LO_W]) : term.val[LO_W-1:0];
	assign pp       = term.mul * part;
	assign acc_next = acc_q + (cnt_q[0] ? (ACC_W'(pp) << LO_W) : ACC_W'(pp));
	assign trial    = {rem_q, acc_q[ACC_W-1]};
	assign out_free = !rv_q || pop;
	assign job_pop  = (bst_q == B_IDLE) && !job_empty;
	assign empty    = !rv_q;
	assign out_item = res_q;

	always_ff @(posedge clk) begin
		unique case (bst_q)
			B_IDLE: begin
				job_q <= job;
				acc_q <= '0;
			end
			B_MUL: begin
				acc_q <= (cnt_q == MUL_LAST && cfg.norm) ?
					acc_next + ACC_W'(cfg.scale >> 1) : acc_next;
				rem_q <= '0;
				quo_q <= '0;
			end
			B_DIV: begin
				// One restoring step per cycle; only the low quotient byte is kept.
				acc_q <= acc_q << 1;
				if (trial >= {1'b0, cfg.scale}) begin
					rem_q <= DIV_W'(trial - {1'b0, cfg.scale});
					quo_q <= {quo_q[6:0], 1'b1};
				end else begin
					rem_q <= trial[DIV_W-1:0];
					quo_q <= {quo_q[6:0], 1'b0};
				end
			end
			default: begin
				if (out_free) begin
					res_q.position <= job_q.position;
					res_q.line_end <= job_q.line_end;
					if (cfg.norm) begin
						res_q.value <= VALUE_W'(quo_q);
					end else if (acc_q > VALUE_MAX) begin
						res_q.value <= VALUE_MAX[VALUE_W-1:0];
					end else begin
						res_q.value <= acc_q[VALUE_W-1:0];
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= B_IDLE;
			cnt_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			if (pop && rv_q) begin
				rv_q <= 1'b0;
			end
			unique case (bst_q)
				B_IDLE: begin
					if (!job_empty) begin
						cnt_q <= '0;
						bst_q <= B_MUL;
					end
				end
				B_MUL: begin
					if (cnt_q == MUL_LAST) begin
						cnt_q <= '0;
						bst_q <= cfg.norm ? B_DIV : B_OUT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				B_DIV: begin
					if (cnt_q == DIV_LAST) begin
						bst_q <= B_OUT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				default: begin
					if (out_free) begin
						rv_q  <= 1'b1;
						bst_q <= B_IDLE;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/line_area_linear_resampler_top.sv
// When downscaling the front handles each sample in its idle and setup states; when upscaling it
// then issues the sample's results from the start, loop or edge state, with the edge repeats last.
// Each result in the back goes through job load, six 14x27 partial products and the output
// write, with 56 restoring division steps before the write when normalization is on.
// The back multiply-divide unit sets the sustained rate when results are dense.
// Asynchronous active-low reset clears control state and loads the register defaults.
`default_nettype none
`include "line_area_linear_resampler_top_macros.svh"
module line_area_linear_resampler_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lalr_pkg::in_item_t  in_item,
	output logic                empty,
	input  logic                pop,
	output lalr_pkg::out_item_t out_item,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [26:0]         wr_data
);
	import lalr_pkg::*;

	logic [LEN_W-1:0] src_q, dst_q;
	logic             premul_q, norm_q;
	logic [DIV_W-1:0] scale_q;
	logic [LEN_W-1:0] s_eff, d_cl, d_m1;
	logic [LEN_W+4:0] d_max;
	cfg_t             cfg;
	logic             restart;
	logic             job_push, job_full, job_pop, job_empty;
	job_t             job_in, job_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q    <= LEN_W'(2);
			dst_q    <= LEN_W'(2);
			premul_q <= 1'b0;
			norm_q   <= 1'b0;
			scale_q  <= DIV_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SRC_LEN: src_q    <= wr_data[LEN_W-1:0];
				REG_DST_LEN: dst_q    <= wr_data[LEN_W-1:0];
				REG_PREMUL:  premul_q <= wr_data[0];
				REG_NORM:    norm_q   <= wr_data[0];
				REG_SCALE:   scale_q  <= wr_data[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	assign restart = wr_en &&
		(wr_index == REG_SRC_LEN || wr_index == REG_DST_LEN || wr_index == REG_PREMUL);

	// Clamp the lengths to the supported range and the upscale ratio.
	always_comb begin
		if (src_q < LEN_W'(2)) begin
			s_eff = LEN_W'(2);
		end else if (src_q > LEN_W'(MAX_LINE_LEN)) begin
			s_eff = LEN_W'(MAX_LINE_LEN);
		end else begin
			s_eff = src_q;
		end
		if (dst_q == '0) begin
			d_cl = LEN_W'(1);
		end else if (dst_q > LEN_W'(MAX_LINE_LEN)) begin
			d_cl = LEN_W'(MAX_LINE_LEN);
		end else begin
			d_cl = dst_q;
		end
		d_max = (LEN_W+5)'(s_eff) * (LEN_W+5)'(MAX_UPSCALE);
		if ((LEN_W+5)'(d_cl) > d_max) begin
			d_cl = d_max[LEN_W-1:0];
		end
	end

	assign cfg.src_len = s_eff;
	assign cfg.dst_len = d_cl;
	assign cfg.premul  = premul_q;
	assign cfg.norm    = norm_q;
	assign cfg.scale   = (scale_q == '0) ? DIV_W'(1) : scale_q;
	assign d_m1        = d_cl - LEN_W'(1);

	lalr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.restart  (restart),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.job_push (job_push),
		.job      (job_in),
		.job_full (job_full)
	);

	lalr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (job_push),
		.wr_full  (job_full),
		.wr_job   (job_in),
		.rd       (job_pop),
		.rd_empty (job_empty),
		.rd_job   (job_out)
	);

	lalr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

	`LALR_ASSERT_IMPL(a_job_no_overflow, job_push, !job_full)
	`LALR_ASSERT_IMPL(a_line_end_pos, !empty && out_item.line_end, out_item.position == d_m1[POS_W-1:0])
	`LALR_ASSERT_NEXT(a_front_busy, push && !full, full)
endmodule
`default_nettype wire
